// File: design/ggvc_pkg.sv
// Package for the go-to-goal velocity controller: fixed-point constants,
// register indices, reset values and the CORDIC arctangent table.
// No dependencies.
package ggvc_pkg;

	localparam int SQRT_BITS = 25;
	localparam int TABLE_LEN = 24;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic signed [18:0] PI_Q13 = 19'sd25736;
	localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;
	localparam logic signed [32:0] PI_Q28 = 33'sd843314857;

	localparam logic [2:0] REG_MAX_LIN = 3'd0;
	localparam logic [2:0] REG_MAX_TURN = 3'd1;
	localparam logic [2:0] REG_LIN_GAIN = 3'd2;
	localparam logic [2:0] REG_TURN_GAIN = 3'd3;
	localparam logic [2:0] REG_POS_TOL = 3'd4;
	localparam logic [2:0] REG_ANG_TOL = 3'd5;

	localparam logic [14:0] RST_MAX_LIN = 15'd3277;
	localparam logic [14:0] RST_MAX_TURN = 15'd19661;
	localparam logic [15:0] RST_LIN_GAIN = 16'd12288;
	localparam logic [15:0] RST_TURN_GAIN = 16'd4096;
	localparam logic [22:0] RST_POS_TOL = 23'd6554;
	localparam logic [14:0] RST_ANG_TOL = 15'd819;

	function automatic logic signed [32:0] atan_q28(input int idx);
		logic signed [32:0] r;
		case (idx)
			0: r = 33'sd210828714;
			1: r = 33'sd124459457;
			2: r = 33'sd65760959;
			3: r = 33'sd33381290;
			4: r = 33'sd16755422;
			5: r = 33'sd8385879;
			6: r = 33'sd4193963;
			7: r = 33'sd2097109;
			8: r = 33'sd1048571;
			9: r = 33'sd524287;
			10: r = 33'sd262144;
			11: r = 33'sd131072;
			12: r = 33'sd65536;
			13: r = 33'sd32768;
			14: r = 33'sd16384;
			15: r = 33'sd8192;
			16: r = 33'sd4096;
			17: r = 33'sd2048;
			18: r = 33'sd1024;
			19: r = 33'sd512;
			20: r = 33'sd256;
			21: r = 33'sd128;
			22: r = 33'sd64;
			23: r = 33'sd32;
			default: r = 33'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [18:0] wrap19(input logic signed [18:0] a);
		logic signed [18:0] r;
		r = a;
		if (a > PI_Q13)
			r = a - TWO_PI_Q13;
		else if (a < -PI_Q13)
			r = a + TWO_PI_Q13;
		return r;
	endfunction

endpackage

// File: design/go_to_goal_velocity_controller.sv
// Go-to-goal velocity controller, top level and the whole datapath.
// Depends on ggvc_pkg.
//
// Usage: present a target pose and a current pose on the input channel
// (in_valid/in_ready); one word with linear_speed and turn_rate leaves on
// the output channel (out_valid/out_ready) for every input word, in order.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write them only while the block holds
// no words.
// Structure: 31 register stages lie between the input and out_valid:
// three setup stages, 25 stages that each resolve one square-root bit
// (the first CORDIC_STEPS of them, at most TABLE_LEN, also do one CORDIC
// rotation), and three stages of error selection, gain multiply and clamp.
// Throughput is one word per cycle, set by the one-step-per-stage layout,
// unless the receiver stalls: a held output word then freezes the whole
// pipeline and in_ready falls in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
module go_to_goal_velocity_controller #(
	parameter int CORDIC_STEPS = ggvc_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] target_x,
	input  logic signed [23:0] target_y,
	input  logic signed [15:0] target_heading,
	input  logic signed [23:0] robot_x,
	input  logic signed [23:0] robot_y,
	input  logic signed [15:0] current_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] linear_speed,
	output logic signed [15:0] turn_rate,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int D = ggvc_pkg::SQRT_BITS;

	logic [14:0] max_lin_q, max_turn_q, ang_tol_q;
	logic [15:0] lin_gain_q, turn_gain_q;
	logic [22:0] pos_tol_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_lin_q <= ggvc_pkg::RST_MAX_LIN;
			max_turn_q <= ggvc_pkg::RST_MAX_TURN;
			lin_gain_q <= ggvc_pkg::RST_LIN_GAIN;
			turn_gain_q <= ggvc_pkg::RST_TURN_GAIN;
			pos_tol_q <= ggvc_pkg::RST_POS_TOL;
			ang_tol_q <= ggvc_pkg::RST_ANG_TOL;
		end else if (cfg_valid) begin
			case (cfg_index)
				ggvc_pkg::REG_MAX_LIN: max_lin_q <= cfg_data[14:0];
				ggvc_pkg::REG_MAX_TURN: max_turn_q <= cfg_data[14:0];
				ggvc_pkg::REG_LIN_GAIN: lin_gain_q <= cfg_data[15:0];
				ggvc_pkg::REG_TURN_GAIN: turn_gain_q <= cfg_data[15:0];
				ggvc_pkg::REG_POS_TOL: pos_tol_q <= cfg_data[22:0];
				ggvc_pkg::REG_ANG_TOL: ang_tol_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	logic ce;
	assign ce = !out_valid || out_ready;
	assign in_ready = ce;

	// stage 1: differences
	logic v_s1;
	logic signed [24:0] dx_s1, dy_s1;
	logic signed [18:0] hn_s1;
	logic signed [15:0] ch_s1;
	logic signed [18:0] hd;
	assign hd = {{3{target_heading[15]}}, target_heading}
		- {{3{current_heading[15]}}, current_heading};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (ce) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			dx_s1 <= {target_x[23], target_x} - {robot_x[23], robot_x};
			dy_s1 <= {target_y[23], target_y} - {robot_y[23], robot_y};
			hn_s1 <= ggvc_pkg::wrap19(hd);
			ch_s1 <= current_heading;
		end
	end

	// stage 2: squares
	logic v_s2;
	logic signed [24:0] dx_s2, dy_s2;
	logic signed [18:0] hn_s2;
	logic signed [15:0] ch_s2;
	logic [48:0] sqx_s2, sqy_s2;
	logic signed [49:0] px, py;
	assign px = dx_s1 * dx_s1;
	assign py = dy_s1 * dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (ce) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			sqx_s2 <= px[48:0];
			sqy_s2 <= py[48:0];
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			hn_s2 <= hn_s1;
			ch_s2 <= ch_s1;
		end
	end

	// per-stage arrays, index 0 is the setup output
	logic v_sk [0:D];
	logic [49:0] sv_sk [0:D];
	logic [26:0] rem_sk [0:D];
	logic [24:0] root_sk [0:D];
	logic signed [47:0] x_sk [0:D];
	logic signed [47:0] y_sk [0:D];
	logic signed [32:0] z_sk [0:D];
	logic zero_sk [0:D];
	logic signed [18:0] hn_sk [0:D];
	logic signed [15:0] ch_sk [0:D];

	// stage 3: sum and CORDIC pre-rotation
	logic signed [47:0] x0, y0;
	assign x0 = {{3{dx_s2[24]}}, dx_s2, 20'd0};
	assign y0 = {{3{dy_s2[24]}}, dy_s2, 20'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sk[0] <= 1'b0;
		else if (ce) v_sk[0] <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			sv_sk[0] <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			rem_sk[0] <= '0;
			root_sk[0] <= '0;
			if (x0 < 0) begin
				x_sk[0] <= -x0;
				y_sk[0] <= -y0;
				z_sk[0] <= (y0 >= 0) ? ggvc_pkg::PI_Q28 : -ggvc_pkg::PI_Q28;
			end else begin
				x_sk[0] <= x0;
				y_sk[0] <= y0;
				z_sk[0] <= '0;
			end
			zero_sk[0] <= (dx_s2 == 0) && (dy_s2 == 0);
			hn_sk[0] <= hn_s2;
			ch_sk[0] <= ch_s2;
		end
	end

	// square-root bit per stage, and a CORDIC rotation in each stage k below CORDIC_STEPS and TABLE_LEN
	for (genvar k = 0; k < D; k++) begin : g_stage
		logic [28:0] rt;
		logic [28:0] trial;
		assign rt = {rem_sk[k], sv_sk[k][49:48]};
		assign trial = {2'b00, root_sk[k][24:0], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_sk[k+1] <= 1'b0;
			else if (ce) v_sk[k+1] <= v_sk[k];
		end
		always_ff @(posedge clk) begin
			if (ce) begin
				sv_sk[k+1] <= {sv_sk[k][47:0], 2'b00};
				if (rt >= trial) begin
					rem_sk[k+1] <= 27'(rt - trial);
					root_sk[k+1] <= {root_sk[k][23:0], 1'b1};
				end else begin
					rem_sk[k+1] <= rt[26:0];
					root_sk[k+1] <= {root_sk[k][23:0], 1'b0};
				end
				if (k < CORDIC_STEPS && k < ggvc_pkg::TABLE_LEN) begin
					if (y_sk[k] > 0) begin
						x_sk[k+1] <= x_sk[k] + (y_sk[k] >>> k);
						y_sk[k+1] <= y_sk[k] - (x_sk[k] >>> k);
						z_sk[k+1] <= z_sk[k] + ggvc_pkg::atan_q28(k);
					end else begin
						x_sk[k+1] <= x_sk[k] - (y_sk[k] >>> k);
						y_sk[k+1] <= y_sk[k] + (x_sk[k] >>> k);
						z_sk[k+1] <= z_sk[k] - ggvc_pkg::atan_q28(k);
					end
				end else begin
					x_sk[k+1] <= x_sk[k];
					y_sk[k+1] <= y_sk[k];
					z_sk[k+1] <= z_sk[k];
				end
				zero_sk[k+1] <= zero_sk[k];
				hn_sk[k+1] <= hn_sk[k];
				ch_sk[k+1] <= ch_sk[k];
			end
		end
	end

	// post stage 1: error select and flags
	logic signed [32:0] zr;
	logic signed [18:0] bearing, ef, esel;
	logic [18:0] emag;
	logic near;
	assign zr = z_sk[D] + 33'sd16384;
	assign bearing = zero_sk[D] ? 19'sd0 : {zr[32], zr[32:15]};
	assign ef = ggvc_pkg::wrap19(bearing - {{3{ch_sk[D][15]}}, ch_sk[D]});
	assign near = {2'b00, root_sk[D]} < {4'd0, pos_tol_q};
	assign esel = near ? hn_sk[D] : ef;
	assign emag = esel[18] ? 19'(-esel) : esel;

	logic v_p1, neg_p1, kill_p1, lin_ok_p1;
	logic [18:0] mag_p1;
	logic [24:0] dist_p1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p1 <= 1'b0;
		else if (ce) v_p1 <= v_sk[D];
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			neg_p1 <= esel[18];
			mag_p1 <= emag;
			dist_p1 <= root_sk[D];
			kill_p1 <= near && (emag < {4'd0, ang_tol_q});
			lin_ok_p1 <= !near && (emag <= {4'd0, ang_tol_q});
		end
	end

	// post stage 2: gain products
	logic v_p2, neg_p2, kill_p2, lin_ok_p2;
	logic [34:0] tp_p2;
	logic [40:0] lp_p2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_p2 <= 1'b0;
		else if (ce) v_p2 <= v_p1;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			tp_p2 <= turn_gain_q * mag_p1;
			lp_p2 <= lin_gain_q * dist_p1;
			neg_p2 <= neg_p1;
			kill_p2 <= kill_p1;
			lin_ok_p2 <= lin_ok_p1;
		end
	end

	// post stage 3: rounding, clamp, output word
	logic [34:0] tr;
	logic [40:0] lr;
	logic [14:0] tc, lc;
	assign tr = (tp_p2 + 35'd2048) >> 12;
	assign lr = (lp_p2 + 41'd16384) >> 15;
	assign tc = (tr > {20'd0, max_turn_q}) ? max_turn_q : tr[14:0];
	assign lc = (lr > {26'd0, max_lin_q}) ? max_lin_q : lr[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (ce) out_valid <= v_p2;
	end
	always_ff @(posedge clk) begin
		if (ce) begin
			if (kill_p2) turn_rate <= '0;
			else if (neg_p2) turn_rate <= -$signed({1'b0, tc});
			else turn_rate <= $signed({1'b0, tc});
			linear_speed <= lin_ok_p2 ? $signed({1'b0, lc}) : 16'sd0;
		end
	end

	a_lin_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (linear_speed >= 0) && (linear_speed <= $signed({1'b0, max_lin_q})))
		else $error("linear command outside clamp");
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (turn_rate <= $signed({1'b0, max_turn_q}))
			&& (turn_rate >= -$signed({1'b0, max_turn_q})))
		else $error("turn command outside clamp");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(v_p2) && $stable(v_p1))
		else $error("pipeline moved during stall");

endmodule
